// File: design/pac_pkg.sv
// ----------------------------------------------------------------------------
// pac_pkg
// Shared types and constants for the polygon area and centroid core.
// ----------------------------------------------------------------------------
package pac_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int MIN_VERTICES = 3;
    localparam int CNT_W        = 9;   // vertex count width
    localparam int AREA_W       = 41;  // twice the signed area, Q16.16
    localparam int CROSS_W      = 33;  // one cross term
    localparam int SUM_W        = 17;  // coordinate pair sum
    localparam int PROD_W       = 50;  // pair sum times cross term
    localparam int MOM_W        = 58;  // moment accumulators
    localparam int DEN_W        = 43;  // three times the doubled area magnitude
    localparam int DIV_W        = 61;  // rounding numerator
    localparam int QUOT_W       = 16;  // quotient bits before saturation
    localparam int QCNT_W       = 4;   // quotient bit counter
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = 2;

    localparam logic [15:0] POS_LIMIT = 16'd32767;
    localparam logic [15:0] NEG_LIMIT = 16'd32768;

    typedef struct packed {
        logic signed [15:0] x_coord;
        logic signed [15:0] y_coord;
    } t_in_item;

    typedef struct packed {
        logic        [39:0] double_area;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic               status;
    } t_out_item;

    // one polygon edge, from vertex a to vertex b
    typedef struct packed {
        logic signed [15:0] xa;
        logic signed [15:0] ya;
        logic signed [15:0] xb;
        logic signed [15:0] yb;
        logic               last;
    } t_edge;

    typedef enum logic [3:0] {
        B_IDLE,
        B_CROSS,
        B_MOM,
        B_ACC,
        B_AREA,
        B_DLOAD,
        B_DSAT,
        B_DIV,
        B_FIN,
        B_OUT
    } t_back_state;

endpackage

// File: design/pac_queue.sv
// ----------------------------------------------------------------------------
// pac_queue
// Small edge queue between the vertex front end and the arithmetic back end.
// ----------------------------------------------------------------------------
module pac_queue
    import pac_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_edge i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_edge o_data,
    output logic  o_empty
);

    t_edge             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: design/pac_front.sv
// ----------------------------------------------------------------------------
// pac_front
// Takes vertices, tracks first and previous vertex, and issues edges,
// including the closing edge back to the first vertex.
// ----------------------------------------------------------------------------
module pac_front
    import pac_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CNT_W-1:0] i_vertex_count,
    input  logic             i_push,
    input  t_in_item         i_item,
    output logic             o_full,
    output logic             o_q_push,
    output t_edge            o_q_data,
    input  logic             i_q_full
);

    logic signed [15:0] r_first_x, r_first_y, r_prev_x, r_prev_y;
    logic [CNT_W-1:0]   r_seen;
    logic               r_close_pend;
    logic [CNT_W-1:0]   n_eff;
    logic               accept;
    logic               closes;

    // clamp the polygon size to the supported range
    always_comb begin
        n_eff = i_vertex_count;
        if (i_vertex_count < CNT_W'(MIN_VERTICES)) begin
            n_eff = CNT_W'(MIN_VERTICES);
        end else if (i_vertex_count > CNT_W'(MAX_VERTICES)) begin
            n_eff = CNT_W'(MAX_VERTICES);
        end
    end

    assign o_full = r_close_pend || i_q_full;
    assign accept = i_push && !o_full;
    assign closes = ({1'b0, r_seen} + 1'b1) >= {1'b0, n_eff};

    // edge issue: closing edge has priority, input is stalled meanwhile
    always_comb begin
        o_q_data = '0;
        o_q_push = 1'b0;
        if (r_close_pend) begin
            o_q_push = !i_q_full;
            o_q_data = '{xa: r_prev_x, ya: r_prev_y, xb: r_first_x, yb: r_first_y,
                         last: 1'b1};
        end else if (accept && r_seen != '0) begin
            o_q_push = 1'b1;
            o_q_data = '{xa: r_prev_x, ya: r_prev_y, xb: i_item.x_coord,
                         yb: i_item.y_coord, last: 1'b0};
        end
    end

    // vertex registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prev_x <= i_item.x_coord;
            r_prev_y <= i_item.y_coord;
            if (r_seen == '0) begin
                r_first_x <= i_item.x_coord;
                r_first_y <= i_item.y_coord;
            end
        end
    end

    // vertex count and pending close
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen       <= '0;
            r_close_pend <= 1'b0;
        end else begin
            if (r_close_pend && !i_q_full) begin
                r_close_pend <= 1'b0;
            end
            if (accept) begin
                if (r_seen != '0 && closes) begin
                    r_seen       <= '0;
                    r_close_pend <= 1'b1;
                end else begin
                    r_seen <= r_seen + 1'b1;
                end
            end
        end
    end

endmodule

// File: design/pac_back.sv
// ----------------------------------------------------------------------------
// pac_back
// Shoelace accumulation per edge, then area magnitude and, if it is nonzero, a
// bit-serial rounded divide per centroid coordinate, into a result register.
// ----------------------------------------------------------------------------
module pac_back
    import pac_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_edge     i_q_data,
    input  logic      i_q_empty,
    output logic      o_q_pop,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_item o_item
);

    t_back_state r_state, n_state;

    t_edge                      r_edge;
    logic signed [CROSS_W-1:0]  r_cross;
    logic signed [SUM_W-1:0]    r_sx, r_sy;
    logic signed [PROD_W-1:0]   r_mx, r_my;
    logic signed [AREA_W-1:0]   r_area;
    logic signed [MOM_W-1:0]    r_mom_x, r_mom_y;
    logic [DEN_W-1:0]           r_den;
    logic [39:0]                r_darea;
    logic                       r_aneg;
    logic                       r_zero;
    logic                       r_sel;
    logic                       r_neg;
    logic                       r_sat;
    logic [DIV_W-1:0]           r_rem;
    logic [DIV_W-1:0]           r_dsh;
    logic [QUOT_W-1:0]          r_q;
    logic [QCNT_W-1:0]          r_cnt;
    logic signed [15:0]         r_cx, r_cy;
    logic                       r_out_valid;
    t_out_item                  r_out;

    logic signed [31:0]         p1, p2;
    logic [AREA_W-1:0]          area_mag;
    logic signed [MOM_W-1:0]    mom_sel;
    logic [MOM_W-1:0]           mom_mag;
    logic                       ge;
    logic [15:0]                q_lim;
    logic [15:0]                coord;

    assign o_empty = !r_out_valid;
    assign o_item  = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:  if (!i_q_empty) n_state = B_CROSS;
            B_CROSS: n_state = B_MOM;
            B_MOM:   n_state = B_ACC;
            B_ACC:   n_state = r_edge.last ? B_AREA : B_IDLE;
            B_AREA:  n_state = (r_area == '0) ? B_OUT : B_DLOAD;
            B_DLOAD: n_state = B_DSAT;
            B_DSAT:  n_state = B_DIV;
            B_DIV:   if (r_cnt == QCNT_W'(QUOT_W - 1)) n_state = B_FIN;
            B_FIN:   n_state = r_sel ? B_OUT : B_DLOAD;
            B_OUT:   if (!r_out_valid) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // outputs of the sequencer
    assign o_q_pop = (r_state == B_IDLE) && !i_q_empty;

    // datapath helpers
    assign p1       = r_edge.xa * r_edge.yb;
    assign p2       = r_edge.xb * r_edge.ya;
    assign area_mag = r_area[AREA_W-1] ? AREA_W'(-r_area) : AREA_W'(r_area);
    assign mom_sel  = r_sel ? r_mom_y : r_mom_x;
    assign mom_mag  = mom_sel[MOM_W-1] ? MOM_W'(-mom_sel) : MOM_W'(mom_sel);
    assign ge       = r_rem >= r_dsh;

    // rounded quotient, saturated and signed
    always_comb begin
        if (r_neg) begin
            q_lim = (r_sat || r_q > NEG_LIMIT) ? NEG_LIMIT : r_q;
            coord = ~q_lim + 16'd1;
        end else begin
            q_lim = (r_sat || r_q > POS_LIMIT) ? POS_LIMIT : r_q;
            coord = q_lim;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_edge <= i_q_data;
            end
            B_CROSS: begin
                r_cross <= {p1[31], p1} - {p2[31], p2};
                r_sx    <= {r_edge.xa[15], r_edge.xa} + {r_edge.xb[15], r_edge.xb};
                r_sy    <= {r_edge.ya[15], r_edge.ya} + {r_edge.yb[15], r_edge.yb};
            end
            B_MOM: begin
                r_mx <= r_sx * r_cross;
                r_my <= r_sy * r_cross;
            end
            B_AREA: begin
                r_den   <= {2'b00, area_mag} + {1'b0, area_mag, 1'b0};
                r_darea <= (area_mag[AREA_W-1]) ? '1 : area_mag[39:0];
                r_aneg  <= r_area[AREA_W-1];
                r_zero  <= (r_area == '0);
                r_sel   <= 1'b0;
                r_cx    <= '0;
                r_cy    <= '0;
            end
            B_DLOAD: begin
                r_rem <= {2'b00, mom_mag, 1'b0} + {18'd0, r_den};
                r_dsh <= {2'b00, r_den, 1'b0, 15'd0};
                r_neg <= mom_sel[MOM_W-1] != r_aneg;
                r_q   <= '0;
                r_cnt <= '0;
            end
            B_DSAT: begin
                r_sat <= r_rem >= {1'b0, r_den, 1'b0, 16'd0};
            end
            B_DIV: begin
                if (ge) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_dsh <= r_dsh >> 1;
                r_q   <= {r_q[QUOT_W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
            end
            B_FIN: begin
                if (r_sel) begin
                    r_cy <= coord;
                end else begin
                    r_cx <= coord;
                end
                r_sel <= 1'b1;
            end
            B_OUT: begin
                if (!r_out_valid) begin
                    r_out <= '{double_area: r_darea, center_x: r_cx, center_y: r_cy,
                               status: r_zero};
                end
            end
            default: begin
            end
        endcase
    end

    // control state and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_area      <= '0;
            r_mom_x     <= '0;
            r_mom_y     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_MOM) begin
                r_area <= r_area + {{(AREA_W-CROSS_W){r_cross[CROSS_W-1]}}, r_cross};
            end
            if (r_state == B_ACC) begin
                r_mom_x <= r_mom_x + {{(MOM_W-PROD_W){r_mx[PROD_W-1]}}, r_mx};
                r_mom_y <= r_mom_y + {{(MOM_W-PROD_W){r_my[PROD_W-1]}}, r_my};
            end
            if (r_state == B_OUT && !r_out_valid) begin
                r_out_valid <= 1'b1;
                r_area      <= '0;
                r_mom_x     <= '0;
                r_mom_y     <= '0;
            end else if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// File: design/polygon_area_centroid_core.sv
// ----------------------------------------------------------------------------
// polygon_area_centroid_core
// Shoelace polygon area and centroid over a stream of Q8.8 vertices.
// ----------------------------------------------------------------------------
// Vertices enter through push/full, one item per vertex. After vertex_count
// vertices (clamped to 3..256) the polygon is closed and one result item
// appears on the empty/pop side: twice the absolute area in Q16.16 and the
// centroid in Q8.8, rounded and saturated, with status set for zero area.
// The cfg channel writes vertex_count; it is always ready. Write it only
// while the core is idle; the core itself does not enforce this.
// Each edge passes through the back end in turn: queue pop, cross product,
// moment multiply, accumulate. The last vertex adds the closing edge and
// then area magnitude, a load, range check and 16-step shift-subtract
// divide per coordinate, and the result load.
// A 4-entry edge queue lets vertices keep arriving meanwhile.
// Reset clears the counters, sums and result valid flag; vertex_count is 3.
// A result waits in its register while pop is low; further vertices are
// still taken until the edge queue fills, then full stays high.
// ----------------------------------------------------------------------------
module polygon_area_centroid_core
    import pac_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  t_in_item         i_in_item,
    output logic             empty,
    input  logic             pop,
    output t_out_item        o_out_item,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data
);

    logic [CNT_W-1:0] r_vertex_count;
    logic             q_push;
    t_edge            q_wdata;
    logic             q_full;
    logic             q_pop;
    t_edge            q_rdata;
    logic             q_empty;

    // configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= CNT_W'(MIN_VERTICES);
        end else if (i_cfg_valid) begin
            r_vertex_count <= i_cfg_data;
        end
    end

    pac_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_vertex_count (r_vertex_count),
        .i_push         (push),
        .i_item         (i_in_item),
        .o_full         (full),
        .o_q_push       (q_push),
        .o_q_data       (q_wdata),
        .i_q_full       (q_full)
    );

    pac_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    pac_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_data  (q_rdata),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_item    (o_out_item)
    );

endmodule

// File: test/polygon_area_centroid_checker.sv
// ----------------------------------------------------------------------------
// polygon_area_centroid_checker
// Watches the vertex, result and cfg channels of the polygon core, computes
// the expected area and centroid for every closed polygon and compares.
// ----------------------------------------------------------------------------
module polygon_area_centroid_checker
    import pac_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic             i_full,
    input  t_in_item         i_in_item,
    input  logic             i_empty,
    input  logic             i_pop,
    input  t_out_item        i_out_item,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // predictor state
    logic [CNT_W-1:0]   vert_cfg;
    logic signed [31:0] fx, fy, px, py;
    int unsigned        seen;
    logic signed [63:0] area_acc, momx_acc, momy_acc;
    t_out_item          polygon_q[$];

    assign o_pending = polygon_q.size();

    // accumulate one shoelace edge
    task automatic add_edge(input logic signed [31:0] xa, ya, xb, yb);
        logic signed [63:0] cr;
        begin
            cr = 64'(xa) * 64'(yb) - 64'(xb) * 64'(ya);
            area_acc += cr;
            momx_acc += 64'(xa + xb) * cr;
            momy_acc += 64'(ya + yb) * cr;
        end
    endtask

    // rounded, saturated centroid coordinate
    function automatic logic [15:0] centroid_coord(input logic signed [63:0] mom,
                                                   input logic [63:0] den,
                                                   input logic den_neg);
        logic [63:0] num, q;
        logic        neg;
        begin
            num = (mom < 0) ? -mom : mom;
            neg = (mom < 0) != den_neg;
            q = (2 * num + den) / (2 * den);
            if (neg) begin
                if (q > 32768) q = 32768;
                centroid_coord = 16'(65536 - q);
            end else begin
                if (q > 32767) q = 32767;
                centroid_coord = q[15:0];
            end
        end
    endfunction

    // take one vertex item, queue a result when the polygon closes
    task automatic take_vertex(input t_in_item it);
        int unsigned        n;
        logic signed [31:0] x, y;
        logic [63:0]        mag;
        t_out_item          res;
        begin
            x = it.x_coord;
            y = it.y_coord;
            n = vert_cfg;
            if (n < MIN_VERTICES) n = MIN_VERTICES;
            if (n > MAX_VERTICES) n = MAX_VERTICES;
            if (seen == 0) begin
                fx = x;
                fy = y;
            end else begin
                add_edge(px, py, x, y);
            end
            px = x;
            py = y;
            seen++;
            if (seen >= n) begin
                add_edge(x, y, fx, fy);
                mag = (area_acc < 0) ? -area_acc : area_acc;
                res.double_area = (mag > 64'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : mag[39:0];
                if (area_acc == 0) begin
                    res.center_x = '0;
                    res.center_y = '0;
                    res.status   = 1'b1;
                end else begin
                    res.center_x = centroid_coord(momx_acc, 3 * mag, area_acc < 0);
                    res.center_y = centroid_coord(momy_acc, 3 * mag, area_acc < 0);
                    res.status   = 1'b0;
                end
                polygon_q.insert(polygon_q.size(), res);
                seen = 0;
                area_acc = 0;
                momx_acc = 0;
                momy_acc = 0;
            end
        end
    endtask

    // watch channels at the rising edge
    always @(posedge i_clk) begin
        t_out_item exp_res;
        if (!i_rst_n) begin
            vert_cfg = CNT_W'(MIN_VERTICES);
            fx = 0; fy = 0; px = 0; py = 0;
            seen = 0;
            area_acc = 0; momx_acc = 0; momy_acc = 0;
            polygon_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) vert_cfg = i_cfg_data;
            if (i_push && !i_full) take_vertex(i_in_item);
            if (i_pop && !i_empty) begin
                if (polygon_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result item %p", i_out_item);
                end else begin
                    exp_res = polygon_q.pop_front();
                    if (i_out_item !== exp_res) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: expected %p actual %p", exp_res, i_out_item);
                    end
                end
            end
        end
    end

endmodule

// File: test/polygon_area_centroid_core_test.sv
// ----------------------------------------------------------------------------
// polygon_area_centroid_core_test
// Drives vertex streams through the polygon core under several vertex counts
// and handshake pressures; a checker beside the core predicts every result.
// ----------------------------------------------------------------------------
module polygon_area_centroid_core_test;
    import pac_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             push = 1'b0;
    logic             full;
    t_in_item         vertex = '0;
    logic             empty;
    logic             pop = 1'b0;
    t_out_item        result;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data = '0;
    int               fail_count;
    int               pending;
    int               send_idle = 0;
    int               recv_stall = 0;
    bit               hold_off = 0;

    polygon_area_centroid_core dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .push(push), .full(full), .i_in_item(vertex),
        .empty(empty), .pop(pop), .o_out_item(result),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    polygon_area_centroid_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_push(push), .i_full(full), .i_in_item(vertex),
        .i_empty(empty), .i_pop(pop), .i_out_item(result),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: random stalls, plus a long hold-off
    always @(negedge clk) begin
        if (hold_off) pop <= 1'b0;
        else pop <= ($urandom_range(99) >= recv_stall);
    end

    // send one vertex, waiting out full; push stays up for the next item
    task automatic send_vertex(input logic [15:0] x, input logic [15:0] y);
        begin
            while ($urandom_range(99) < send_idle) begin
                push <= 1'b0;
                @(negedge clk);
            end
            push <= 1'b1;
            vertex <= '{x_coord: x, y_coord: y};
            @(posedge clk);
            while (full) @(posedge clk);
            @(negedge clk);
        end
    endtask

    // drain, then write vertex_count while idle
    task automatic set_count(input logic [CNT_W-1:0] n);
        begin
            push <= 1'b0;
            while (pending != 0) @(negedge clk);
            repeat (80) @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_data <= n;
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            @(negedge clk);
            cfg_valid <= 1'b0;
        end
    endtask

    // random coordinate: full range, small values for sane centroids, or extremes
    function automatic logic [15:0] rand_coord();
        case ($urandom_range(3))
            0: rand_coord = 16'($urandom);
            1: rand_coord = 16'($urandom_range(255)) - 16'd128;
            2: rand_coord = 16'($urandom_range(4095)) - 16'd2048;
            default: rand_coord = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        endcase
    endfunction

    // random polygons under one count; occasionally degenerate
    task automatic random_polygons(input int vertices);
        int          k;
        logic [15:0] rx = '0;
        logic [15:0] ry = '0;
        begin
            for (k = 0; k < vertices; k++) begin
                if ($urandom_range(19) == 0) send_vertex(rx, ry);
                else begin
                    rx = rand_coord();
                    ry = rand_coord();
                    send_vertex(rx, ry);
                end
            end
        end
    endtask

    initial begin
        int ph, i;
        int counts[6] = '{3, 4, 5, 7, 3, 6};
        int stall_tbl[4] = '{0, 0, 70, 12};
        int idle_tbl[4] = '{0, 70, 0, 12};
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: extremes, zero area, clockwise and counter-clockwise
        send_vertex(16'h0000, 16'h0000);
        send_vertex(16'h0100, 16'h0000);
        send_vertex(16'h0000, 16'h0100);
        send_vertex(16'h0000, 16'h0000);
        send_vertex(16'h0000, 16'h0100);
        send_vertex(16'h0100, 16'h0000);
        send_vertex(16'h0010, 16'h0010);
        send_vertex(16'h0010, 16'h0010);
        send_vertex(16'h0010, 16'h0010);
        send_vertex(16'h8000, 16'h8000);
        send_vertex(16'h7FFF, 16'h8000);
        send_vertex(16'h7FFF, 16'h7FFF);
        send_vertex(16'h8000, 16'h7FFF);
        send_vertex(16'h7FFF, 16'h8000);
        send_vertex(16'hFFFF, 16'h0000);
        set_count(9'd0);
        send_vertex(16'h0300, 16'h0200);
        send_vertex(16'hFD00, 16'h0100);
        send_vertex(16'h0000, 16'hFC00);
        set_count(9'd511);
        random_polygons(256);
        set_count(9'd256);
        random_polygons(256);
        set_count(9'd4);
        send_vertex(16'h8000, 16'h8000);
        send_vertex(16'h7FFF, 16'h8000);
        // count changed mid-polygon closes it on the next vertex
        set_count(9'd3);
        send_vertex(16'h7FFF, 16'h7FFF);

        // random phases across idling modes
        for (ph = 0; ph < 12; ph++) begin
            set_count(CNT_W'(counts[ph % 6]));
            send_idle = idle_tbl[ph % 4];
            recv_stall = stall_tbl[ph % 4];
            random_polygons(40);
        end
        // long receiver hold-off while vertices keep coming
        send_idle = 0;
        recv_stall = 0;
        fork
            begin
                hold_off = 1;
                for (i = 0; i < 400; i++) @(negedge clk);
                hold_off = 0;
            end
            begin
                random_polygons(60);
                push <= 1'b0;
            end
        join

        while (pending != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        if (fail_count == 0 && pending == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end
endmodule

// File: filelist.f
design/pac_pkg.sv
design/pac_queue.sv
design/pac_front.sv
design/pac_back.sv
design/polygon_area_centroid_core.sv
test/polygon_area_centroid_checker.sv
test/polygon_area_centroid_core_test.sv
